/* rtl/dopq_pkg.sv */
// Package for the deferred-operation priority queue.
// Holds field widths, the entry and result records, op codes and sequencer states.
// No dependencies.
`default_nettype none

package dopq_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int KIND_W = 4;
  localparam int PRIO_W = 2;
  localparam int REG_W  = 8;
  localparam int DATA_W = 8;
  localparam int ADDR_W = 16;
  localparam int OCC_W  = 5;
  localparam int OVF_W  = 32;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 88;
  localparam int M_TUSER_W = 2;

  localparam logic [KIND_W-1:0] KIND_FLAG = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PC   = 4'd6;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_DRAIN = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Field order matches the input tdata layout, lowest bits last.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] dat;
    logic [REG_W-1:0]  dst;
    logic [REG_W-1:0]  src;
    logic [PRIO_W-1:0] prio;
    logic [KIND_W-1:0] kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [OVF_W-1:0] overflow;
    logic [OCC_W-1:0] peak;
    logic [OCC_W-1:0] occupancy;
    logic             last;
    logic             entry_valid;
    logic             accepted;
    entry_t           entry;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POP
  } state_t;

endpackage

`default_nettype wire

/* rtl/dopq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Default sizes come from dopq_pkg.
`default_nettype none

module dopq_ram #(
  parameter int WIDTH = dopq_pkg::ENTRY_W,
  parameter int DEPTH = dopq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/dopq_obuf.sv */
// Output register stage of the queue: holds one result item until taken.
// Uses dopq_pkg for the result record and port widths.
`default_nettype none

module dopq_obuf (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire dopq_pkg::result_t              res,
  output logic                                free,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // entry kind, priority, source, dest, data, address, occupancy, peak, overflows
  output logic [dopq_pkg::M_TDATA_W-1:0]      m_tdata,
  // accepted, entry_valid
  output logic [dopq_pkg::M_TUSER_W-1:0]      m_tuser,
  output logic                                m_tlast
);

  import dopq_pkg::*;

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.overflow, held.peak, held.occupancy, held.entry};
  assign m_tuser = {held.entry_valid, held.accepted};
  assign m_tlast = held.last;

endmodule

`default_nettype wire

/* rtl/deferred_op_priority_queue.sv */
// Deferred-operation priority queue: ring store, scan/shift sequencer, output stage.
// Depends on dopq_pkg, dopq_ram and dopq_obuf.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------------
//  s_      | in  | s_tvalid/tready  | tuser: op; tdata: kind, prio, src, dst, data, addr
//  m_      | out | m_tvalid/tready  | tuser: accepted, entry_valid; tdata: entry + status
//
// Push, clear and no-op items finish once the output register can take their result.
// A drain, per popped entry, scans all entries and then moves those between the head
// and the winner one slot on: one shared slot adder walks the RAM read port.
// Reset is synchronous; the store needs no clearing pass, only written slots are read.
// A stalled output holds the sequencer before the next result; s_tready is high only
// between items.
`default_nettype none

module deferred_op_priority_queue #(
  parameter int QUEUE_DEPTH = dopq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // op_type, priority_req, source, dest, data, address, zero fill
  input  wire logic [dopq_pkg::S_TDATA_W-1:0] s_tdata,
  // op
  input  wire logic [dopq_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // entry_kind, entry_priority, entry_source, entry_dest, entry_data,
  // entry_address, occupancy, peak, overflow_count
  output logic [dopq_pkg::M_TDATA_W-1:0]      m_tdata,
  // accepted, entry_valid
  output logic [dopq_pkg::M_TUSER_W-1:0]      m_tuser,
  output logic                                m_tlast
);

  import dopq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

  state_t state, state_next;

  op_t    item_op;
  entry_t item_entry;

  logic [IDX_W-1:0] head, tail;
  logic [CNT_W-1:0] count, ready_cnt, peak;
  logic [OVF_W-1:0] overflow;
  logic             popped_any;
  logic [QUEUE_DEPTH-1:0] waiting;

  logic [CNT_W-1:0] rd_off;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_off, cmp_slot;
  logic [IDX_W-1:0] best_off, best_off_upd;
  entry_t           best_entry;
  logic             best_wait;
  logic [IDX_W-1:0] sh_off;
  logic             sh_wait;

  logic [CNT_W-1:0] off_sel;
  logic [SUM_W-1:0] slot_sum;
  logic [IDX_W-1:0] slot;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata, ram_rdata;

  logic             issue, cmp_take, scan_done, age, push_full, push_waits;
  logic [CNT_W-1:0] cnt_inc, cnt_dec, rdy_dec, peak_push;
  logic [IDX_W-1:0] head_inc, tail_inc;

  logic    load, out_free;
  result_t res;

  dopq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  dopq_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign s_tready = (state == S_IDLE);

  // shared slot adder: head plus an offset, wrapped into the ring
  always_comb begin
    case (state)
      S_SCAN:     off_sel = rd_off;
      S_SHIFT_RD: off_sel = CNT_W'(sh_off - IDX_W'(1));
      S_SHIFT_WR: off_sel = CNT_W'(sh_off);
      default:    off_sel = '0;
    endcase
    slot_sum = SUM_W'(head) + SUM_W'(off_sel);
    if (slot_sum >= SUM_DEPTH) begin
      slot = IDX_W'(slot_sum - SUM_DEPTH);
    end else begin
      slot = IDX_W'(slot_sum);
    end
  end

  assign issue        = (state == S_SCAN) && (rd_off < count);
  assign cmp_take     = cmp_valid && ((cmp_off == '0) || (ram_rdata.prio > best_entry.prio));
  assign scan_done    = cmp_valid && (CNT_W'(cmp_off) == count - CNT_W'(1));
  assign best_off_upd = cmp_take ? cmp_off : best_off;

  assign push_full  = (count == CNT_FULL);
  assign push_waits = !((item_entry.kind == KIND_FLAG) || (item_entry.kind == KIND_PC));
  assign cnt_inc    = count + CNT_W'(1);
  assign cnt_dec    = count - CNT_W'(1);
  assign rdy_dec    = ready_cnt - CNT_W'(!best_wait);
  assign peak_push  = (cnt_inc > peak) ? cnt_inc : peak;
  assign head_inc   = (head == IDX_LAST) ? '0 : head + IDX_W'(1);
  assign tail_inc   = (tail == IDX_LAST) ? '0 : tail + IDX_W'(1);
  assign age        = (state == S_CHECK) && (state_next == S_IDLE);

  always_comb begin
    state_next     = state;
    load           = 1'b0;
    res            = '0;
    res.occupancy  = OCC_W'(count);
    res.peak       = OCC_W'(peak);
    res.overflow   = overflow;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = item_entry;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_op)
          OP_DRAIN: begin
            state_next = S_CHECK;
          end
          OP_PUSH: begin
            if (out_free) begin
              load       = 1'b1;
              res.last   = 1'b1;
              state_next = S_IDLE;
              if (push_full) begin
                res.overflow = overflow + OVF_W'(1);
              end else begin
                res.accepted  = 1'b1;
                res.occupancy = OCC_W'(cnt_inc);
                res.peak      = OCC_W'(peak_push);
                ram_we        = 1'b1;
              end
            end
          end
          default: begin
            if (out_free) begin
              load       = 1'b1;
              res.last   = 1'b1;
              state_next = S_IDLE;
              if (item_op == OP_CLEAR) begin
                res.occupancy = '0;
              end
            end
          end
        endcase
      end
      S_CHECK: begin
        if ((count == '0) || (ready_cnt == '0)) begin
          if (popped_any) begin
            state_next = S_IDLE;
          end else if (out_free) begin
            load       = 1'b1;
            res.last   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = (best_off_upd == '0) ? S_POP : S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = slot;
        ram_wdata  = ram_rdata;
        state_next = (sh_off == IDX_W'(1)) ? S_POP : S_SHIFT_RD;
      end
      S_POP: begin
        if (out_free) begin
          load            = 1'b1;
          res.entry_valid = 1'b1;
          res.entry       = best_entry;
          res.occupancy   = OCC_W'(cnt_dec);
          res.last        = (cnt_dec == '0) || (rdy_dec == '0);
          state_next      = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      ready_cnt  <= '0;
      peak       <= '0;
      overflow   <= '0;
      popped_any <= 1'b0;
      cmp_valid  <= 1'b0;
      rd_off     <= '0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      case (state)
        S_IDLE: begin
          popped_any <= 1'b0;
        end
        S_EXEC: begin
          if (load && (item_op == OP_PUSH)) begin
            if (push_full) begin
              overflow <= overflow + OVF_W'(1);
            end else begin
              tail      <= tail_inc;
              count     <= cnt_inc;
              peak      <= peak_push;
              ready_cnt <= ready_cnt + CNT_W'(!push_waits);
            end
          end
          if (load && (item_op == OP_CLEAR)) begin
            head      <= '0;
            tail      <= '0;
            count     <= '0;
            ready_cnt <= '0;
          end
        end
        S_CHECK: begin
          if (age) begin
            ready_cnt <= count;
          end
          rd_off <= '0;
        end
        S_SCAN: begin
          if (issue) begin
            rd_off <= rd_off + CNT_W'(1);
          end
        end
        S_POP: begin
          if (load) begin
            head       <= head_inc;
            count      <= cnt_dec;
            ready_cnt  <= rdy_dec;
            popped_any <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op    <= op_t'(s_tuser);
      item_entry <= entry_t'(s_tdata[ENTRY_W-1:0]);
    end
    cmp_off  <= IDX_W'(rd_off);
    cmp_slot <= slot;
    if (cmp_take) begin
      best_off   <= cmp_off;
      best_entry <= ram_rdata;
      best_wait  <= waiting[cmp_slot];
    end
    if (state == S_SCAN && scan_done) begin
      sh_off <= best_off_upd;
    end else if (state == S_SHIFT_WR) begin
      sh_off <= sh_off - IDX_W'(1);
    end
    if (state == S_SHIFT_RD) begin
      sh_wait <= waiting[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (age) begin
      waiting <= '0;
    end else if (state == S_EXEC && load && item_op == OP_PUSH && !push_full) begin
      waiting[tail] <= push_waits;
    end else if (state == S_SHIFT_WR) begin
      waiting[slot] <= sh_wait;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue holds more entries than its depth");

  a_ready_bound: assert property (@(posedge clk) disable iff (rst)
    ready_cnt <= count)
    else $error("ready count exceeds occupancy");

  a_shift_offset: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_RD || state == S_SHIFT_WR) |-> (sh_off != '0))
    else $error("shift step with zero offset");

  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && load && res.last) |=> (count == '0 || ready_cnt == '0))
    else $error("final pop flagged while ready entries remain");

endmodule

`default_nettype wire

/* bench/deferred_op_priority_queue_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the deferred-operation priority queue: directed and random
// push, drain, clear and no-op items, predicted in-bench and compared field by field
// on the stream. Depends on dopq_pkg and deferred_op_priority_queue.
module deferred_op_priority_queue_tb;
  import dopq_pkg::*;

  localparam int DEPTH         = DEFAULT_DEPTH;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;

  localparam logic [KIND_W-1:0] KIND_NONE  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_STORE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_ALU   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_BUS   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_PUSH  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_PULL  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_ADDR  = 4'd9;
  localparam logic [KIND_W-1:0] KIND_TOP   = 4'd15;

  localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_URGENT = 2'd3;

  typedef struct {
    entry_t payload;
    logic   deferred;
  } held_op_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;

  held_op_t         held_ops[$];
  result_t          expected_results[$];
  logic [OCC_W-1:0] peak_model;
  logic [OVF_W-1:0] overflow_model;
  int               mismatch_count;
  result_t          want;

  deferred_op_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("** deferred_op_priority_queue: FAILED **");
    $finish;
  end

  function automatic entry_t mk_entry(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                                      logic [REG_W-1:0] src, logic [REG_W-1:0] dst,
                                      logic [DATA_W-1:0] dat, logic [ADDR_W-1:0] addr);
    entry_t e;
    e.kind = kind;
    e.prio = prio;
    e.src  = src;
    e.dst  = dst;
    e.dat  = dat;
    e.addr = addr;
    return e;
  endfunction

  function automatic entry_t rand_entry();
    int               pick;
    logic [KIND_W-1:0] kind;
    pick = $urandom_range(0, 9);
    if (pick < 3)
      kind = $urandom_range(0, 1) ? KIND_FLAG : KIND_PC;
    else if (pick == 3)
      kind = KIND_W'($urandom_range(10, 15));
    else
      kind = KIND_W'($urandom_range(0, 9));
    return mk_entry(kind, PRIO_W'($urandom_range(0, 3)), REG_W'($urandom_range(0, 255)),
                    REG_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
                    ADDR_W'($urandom_range(0, 65535)));
  endfunction

  function automatic logic has_ready();
    foreach (held_ops[i])
      if (!held_ops[i].deferred) return 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t make_result(entry_t e, logic valid, logic acc, logic last);
    result_t r;
    r = '0;
    if (valid) r.entry = e;
    r.entry_valid = valid;
    r.accepted    = acc;
    r.last        = last;
    r.occupancy   = OCC_W'(held_ops.size());
    r.peak        = peak_model;
    r.overflow    = overflow_model;
    return r;
  endfunction

  task automatic predict_queue_op(op_t op, entry_t e);
    held_op_t slot;
    entry_t   popped;
    int       best;
    int       pops;
    case (op)
      OP_PUSH: begin
        if (held_ops.size() >= DEPTH) begin
          overflow_model = overflow_model + 1;
          expected_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
        end else begin
          slot.payload  = e;
          slot.deferred = !(e.kind == KIND_FLAG || e.kind == KIND_PC);
          held_ops.push_back(slot);
          if (held_ops.size() > peak_model) peak_model = OCC_W'(held_ops.size());
          expected_results.push_back(make_result('0, 1'b0, 1'b1, 1'b1));
        end
      end
      OP_DRAIN: begin
        pops = 0;
        while (held_ops.size() > 0 && has_ready()) begin
          best = 0;
          for (int i = 1; i < held_ops.size(); i++)
            if (held_ops[i].payload.prio > held_ops[best].payload.prio) best = i;
          popped = held_ops[best].payload;
          held_ops.delete(best);
          pops++;
          expected_results.push_back(make_result(popped, 1'b1, 1'b0, !has_ready()));
        end
        foreach (held_ops[i]) held_ops[i].deferred = 1'b0;
        if (pops == 0) expected_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
      end
      OP_CLEAR: begin
        held_ops.delete();
        expected_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
      end
      default: expected_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
    endcase
  endtask

  task automatic send_item(op_t op, entry_t e);
    int gap;
    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(S_TDATA_W - ENTRY_W){1'b0}}, e};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_queue_op(op, e);
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [OVF_W-1:0] exp_val,
                             logic [OVF_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      int stall;
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected item, expected none, got tdata %0h tuser %0h last %0b",
                   $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = expected_results.pop_front();
        check_field("entry_kind", OVF_W'(want.entry.kind), OVF_W'(m_tdata[3:0]));
        check_field("entry_priority", OVF_W'(want.entry.prio), OVF_W'(m_tdata[5:4]));
        check_field("entry_source", OVF_W'(want.entry.src), OVF_W'(m_tdata[13:6]));
        check_field("entry_dest", OVF_W'(want.entry.dst), OVF_W'(m_tdata[21:14]));
        check_field("entry_data", OVF_W'(want.entry.dat), OVF_W'(m_tdata[29:22]));
        check_field("entry_address", OVF_W'(want.entry.addr), OVF_W'(m_tdata[45:30]));
        check_field("occupancy", OVF_W'(want.occupancy), OVF_W'(m_tdata[ENTRY_W +: OCC_W]));
        check_field("peak", OVF_W'(want.peak),
                    OVF_W'(m_tdata[ENTRY_W + OCC_W +: OCC_W]));
        check_field("overflow_count", want.overflow, m_tdata[ENTRY_W + 2*OCC_W +: OVF_W]);
        check_field("accepted", OVF_W'(want.accepted), OVF_W'(m_tuser[0]));
        check_field("entry_valid", OVF_W'(want.entry_valid), OVF_W'(m_tuser[1]));
        check_field("last", OVF_W'(want.last), OVF_W'(m_tlast));
      end
    end
  end

  task automatic test_idle_ops();
    send_item(OP_DRAIN, '0);
    send_item(OP_NOP, mk_entry(KIND_TOP, PRIO_URGENT, 8'hff, 8'hff, 8'hff, 16'hffff));
  endtask

  task automatic test_priority_order();
    send_item(OP_PUSH, mk_entry(KIND_ALU, PRIO_URGENT, 8'h01, 8'h02, 8'h03, 16'h0004));
    send_item(OP_PUSH, mk_entry(KIND_FLAG, PRIO_LOW, 8'h00, 8'h00, 8'h00, 16'h0000));
    send_item(OP_PUSH, mk_entry(KIND_PC, PRIO_URGENT, 8'hff, 8'h00, 8'hff, 16'h8000));
    send_item(OP_PUSH, mk_entry(KIND_TOP, PRIO_HIGH, 8'hff, 8'hff, 8'hff, 16'hffff));
    send_item(OP_PUSH, mk_entry(KIND_LOAD, PRIO_URGENT, 8'h5a, 8'ha5, 8'h3c, 16'h1234));
    send_item(OP_DRAIN, '0);
  endtask

  task automatic test_overflow_and_clear();
    logic [KIND_W-1:0] kinds[10];
    kinds = '{KIND_NONE, KIND_LOAD, KIND_STORE, KIND_ALU, KIND_FLAG,
              KIND_BUS, KIND_PC, KIND_PUSH, KIND_PULL, KIND_ADDR};
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_PUSH, mk_entry(kinds[i % 10], PRIO_W'(i), i[0] ? 8'hff : 8'h00,
                                  i[0] ? 8'h00 : 8'hff, i[1] ? 8'hff : 8'h00,
                                  i[0] ? 16'hffff : 16'h0000));
    send_item(OP_PUSH, mk_entry(KIND_FLAG, PRIO_NORMAL, 8'hff, 8'hff, 8'hff, 16'hffff));
    send_item(OP_CLEAR, '0);
  endtask

  task automatic test_random_traffic(int n_items);
    int  sent;
    int  pick;
    int  burst;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        burst = $urandom_range(0, 5) == 0 ? $urandom_range(10, DEPTH + 2) : $urandom_range(1, 6);
        repeat (burst) send_item(OP_PUSH, rand_entry());
        sent += burst;
        burst = $urandom_range(1, 3);
        repeat (burst) send_item(OP_DRAIN, rand_entry());
        sent += burst;
      end else if (pick == 7) begin
        send_item(OP_CLEAR, rand_entry());
        sent++;
      end else begin
        send_item(op_t'($urandom_range(0, 3)), rand_entry());
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        wait_results_done();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_NOP;
    mismatch_count = 0;
    peak_model     = '0;
    overflow_model = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_idle_ops();
    test_priority_order();
    test_overflow_and_clear();
    test_random_traffic(225);

    wait_results_done();
    if (mismatch_count == 0)
      $display("** deferred_op_priority_queue: PASSED **");
    else
      $display("** deferred_op_priority_queue: FAILED **");
    $finish;
  end

endmodule
